// ----- src/vgib_pkg.sv -----
`timescale 1ns / 1ps

package vgib_pkg;

    // Operation codes of an input request.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SLOT  = 2'd1;
    localparam logic [1:0] OP_GROUP = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NUM_POSITIONS = 2'd0;
    localparam logic [1:0] CFG_POSITION_BASE = 2'd1;
    localparam logic [1:0] CFG_ID_OFFSET     = 2'd2;

    // One input request.
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] raw_position;
        logic [9:0]  slot;
        logic [7:0]  group;
    } vgib_req_t;

    // One result.
    typedef struct packed {
        logic [15:0] vertex_id;
        logic [10:0] group_start;
        logic [10:0] group_length;
        logic [1:0]  status;
    } vgib_res_t;

    // Configuration register set.
    typedef struct packed {
        logic [8:0]  num_positions;
        logic [15:0] position_base;
        logic [15:0] id_offset;
    } vgib_cfg_t;

endpackage

// ----- src/vgib_addsub.sv -----
`timescale 1ns / 1ps

module vgib_addsub #(
    parameter int W = 16
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W:0]   result
);

    // Shared adder: a + b, or a - b with the top bit as the no-borrow flag.
    assign result = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);

endmodule

// ----- src/vgib_core.sv -----
`timescale 1ns / 1ps

module vgib_core
    import vgib_pkg::*;
#(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_POSITIONS = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  vgib_req_t req,
    input  vgib_cfg_t cfg,
    output logic      idle,
    output logic      res_valid,
    input  logic      res_ready,
    output vgib_res_t res
);

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int PIDX_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int GE_W   = ($clog2(MAX_POSITIONS + 1) > 9) ? $clog2(MAX_POSITIONS + 1) : 9;
    localparam int W      = (CNT_W > 16) ? CNT_W : 16;
    localparam int CW     = (W > GE_W) ? W : GE_W;
    localparam int SW     = (CNT_W > 10) ? CNT_W : 10;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_SUB,
        S_LD_CHK,
        S_LD_INC,
        S_B_SUM_RD,
        S_B_SUM_WR,
        S_B_SC_VP,
        S_B_SC_FC,
        S_B_SC_WR,
        S_RD_SLOT,
        S_RD_VID,
        S_RD_GRP,
        S_RD_GINFO,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    vgib_req_t         req_reg, req_next;
    vgib_res_t         res_reg, res_next;
    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic              built_reg, built_next;
    logic              clr_reply_reg, clr_reply_next;
    logic [PIDX_W-1:0] g_reg, g_next;
    logic [CNT_W-1:0]  v_reg, v_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [W-1:0]      diff_reg, diff_next;
    logic              borrow_reg, borrow_next;

    // Shared adder operands.
    logic [W-1:0] add_a, add_b;
    logic         add_sub;
    logic [W:0]   add_res;

    // Memory ports.
    logic              vp_we, vp_re;
    logic [VIDX_W-1:0] vp_waddr, vp_raddr;
    logic [PIDX_W-1:0] vp_wdata, vp_rdata;
    logic              gc_we, gc_re;
    logic [PIDX_W-1:0] gc_waddr, gc_raddr;
    logic [CNT_W-1:0]  gc_wdata, gc_rdata;
    logic              gf_we, gf_re;
    logic [PIDX_W-1:0] gf_waddr, gf_raddr;
    logic [CNT_W-1:0]  gf_wdata, gf_rdata;
    logic              fc_we, fc_re;
    logic [PIDX_W-1:0] fc_waddr, fc_raddr;
    logic [CNT_W-1:0]  fc_wdata, fc_rdata;
    logic              gv_we, gv_re;
    logic [VIDX_W-1:0] gv_waddr, gv_raddr;
    logic [VIDX_W-1:0] gv_wdata, gv_rdata;

    logic [PIDX_W-1:0] vp_mem [MAX_VERTICES];
    logic [CNT_W-1:0]  gc_mem [MAX_POSITIONS];
    logic [CNT_W-1:0]  gf_mem [MAX_POSITIONS];
    logic [CNT_W-1:0]  fc_mem [MAX_POSITIONS];
    logic [VIDX_W-1:0] gv_mem [MAX_VERTICES];

    // Effective group count and range checks.
    logic [GE_W-1:0] groups_eff;
    logic            load_out_of_range;
    logic            store_full;
    logic            slot_beyond;
    logic            group_beyond;
    logic            last_vertex;

    assign groups_eff = (GE_W'(cfg.num_positions) > GE_W'(MAX_POSITIONS))
                        ? GE_W'(MAX_POSITIONS) : GE_W'(cfg.num_positions);
    assign load_out_of_range = borrow_reg || (CW'(diff_reg) >= CW'(groups_eff));
    assign store_full   = (loaded_reg == CNT_W'(MAX_VERTICES));
    assign slot_beyond  = (SW'(req_reg.slot) >= SW'(loaded_reg));
    assign group_beyond = (GE_W'(req_reg.group) >= groups_eff);
    assign last_vertex  = ((v_reg + CNT_W'(1)) == loaded_reg);

    vgib_addsub #(
        .W (W)
    ) u_addsub (
        .a      (add_a),
        .b      (add_b),
        .sub    (add_sub),
        .result (add_res)
    );

    // Sequencer next-state and memory control.
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        loaded_next    = loaded_reg;
        built_next     = built_reg;
        clr_reply_next = clr_reply_reg;
        g_next         = g_reg;
        v_next         = v_reg;
        run_next       = run_reg;
        diff_next      = diff_reg;
        borrow_next    = borrow_reg;
        add_a          = '0;
        add_b          = '0;
        add_sub        = 1'b0;
        vp_we = 1'b0; vp_re = 1'b0; vp_waddr = '0; vp_raddr = '0; vp_wdata = '0;
        gc_we = 1'b0; gc_re = 1'b0; gc_waddr = '0; gc_raddr = '0; gc_wdata = '0;
        gf_we = 1'b0; gf_re = 1'b0; gf_waddr = '0; gf_raddr = '0; gf_wdata = '0;
        fc_we = 1'b0; fc_re = 1'b0; fc_waddr = '0; fc_raddr = '0; fc_wdata = '0;
        gv_we = 1'b0; gv_re = 1'b0; gv_waddr = '0; gv_raddr = '0; gv_wdata = '0;

        case (state_reg)
            S_CLEAR: begin
                gc_we    = 1'b1;
                gc_waddr = g_reg;
                gc_wdata = '0;
                if (g_reg == PIDX_W'(MAX_POSITIONS - 1)) begin
                    g_next     = '0;
                    state_next = clr_reply_reg ? S_DONE : S_IDLE;
                end else begin
                    g_next = g_reg + PIDX_W'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    req_next = req;
                    res_next = '0;
                    case (req.operation)
                        OP_LOAD: begin
                            state_next = S_LD_SUB;
                        end
                        OP_SLOT, OP_GROUP: begin
                            if (built_reg) begin
                                state_next = (req.operation == OP_SLOT) ? S_RD_SLOT : S_RD_GRP;
                            end else begin
                                g_next     = '0;
                                run_next   = '0;
                                state_next = S_B_SUM_RD;
                            end
                        end
                        default: begin
                            loaded_next    = '0;
                            built_next     = 1'b0;
                            clr_reply_next = 1'b1;
                            g_next         = '0;
                            state_next     = S_CLEAR;
                        end
                    endcase
                end
            end
            // Load: subtract the base, then check range and room.
            S_LD_SUB: begin
                add_a       = W'(req_reg.raw_position);
                add_b       = W'(cfg.position_base);
                add_sub     = 1'b1;
                diff_next   = add_res[W-1:0];
                borrow_next = !add_res[W];
                state_next  = S_LD_CHK;
            end
            S_LD_CHK: begin
                if (load_out_of_range) begin
                    res_next.status = ST_RANGE;
                    state_next      = S_DONE;
                end else if (store_full) begin
                    res_next.status = ST_FULL;
                    state_next      = S_DONE;
                end else begin
                    vp_we       = 1'b1;
                    vp_waddr    = VIDX_W'(loaded_reg);
                    vp_wdata    = PIDX_W'(diff_reg);
                    gc_re       = 1'b1;
                    gc_raddr    = PIDX_W'(diff_reg);
                    loaded_next = loaded_reg + CNT_W'(1);
                    built_next  = 1'b0;
                    state_next  = S_LD_INC;
                end
            end
            S_LD_INC: begin
                add_a      = W'(gc_rdata);
                add_b      = W'(1);
                gc_we      = 1'b1;
                gc_waddr   = PIDX_W'(diff_reg);
                gc_wdata   = CNT_W'(add_res);
                state_next = S_DONE;
            end
            // Build, first pass: prefix sum of the group counts.
            S_B_SUM_RD: begin
                gc_re      = 1'b1;
                gc_raddr   = g_reg;
                state_next = S_B_SUM_WR;
            end
            S_B_SUM_WR: begin
                add_a    = W'(run_reg);
                add_b    = W'(gc_rdata);
                gf_we    = 1'b1;
                gf_waddr = g_reg;
                gf_wdata = run_reg;
                fc_we    = 1'b1;
                fc_waddr = g_reg;
                fc_wdata = run_reg;
                run_next = CNT_W'(add_res);
                if (g_reg == PIDX_W'(MAX_POSITIONS - 1)) begin
                    g_next = '0;
                    if (loaded_reg == '0) begin
                        built_next = 1'b1;
                        state_next = (req_reg.operation == OP_SLOT) ? S_RD_SLOT : S_RD_GRP;
                    end else begin
                        v_next     = '0;
                        state_next = S_B_SC_VP;
                    end
                end else begin
                    g_next     = g_reg + PIDX_W'(1);
                    state_next = S_B_SUM_RD;
                end
            end
            // Build, second pass: stable scatter of vertex numbers.
            S_B_SC_VP: begin
                vp_re      = 1'b1;
                vp_raddr   = VIDX_W'(v_reg);
                state_next = S_B_SC_FC;
            end
            S_B_SC_FC: begin
                fc_re      = 1'b1;
                fc_raddr   = vp_rdata;
                state_next = S_B_SC_WR;
            end
            S_B_SC_WR: begin
                add_a    = W'(fc_rdata);
                add_b    = W'(1);
                gv_we    = 1'b1;
                gv_waddr = VIDX_W'(fc_rdata);
                gv_wdata = VIDX_W'(v_reg);
                fc_we    = 1'b1;
                fc_waddr = vp_rdata;
                fc_wdata = CNT_W'(add_res);
                if (last_vertex) begin
                    built_next = 1'b1;
                    state_next = (req_reg.operation == OP_SLOT) ? S_RD_SLOT : S_RD_GRP;
                end else begin
                    v_next     = v_reg + CNT_W'(1);
                    state_next = S_B_SC_VP;
                end
            end
            // Slot read.
            S_RD_SLOT: begin
                if (slot_beyond) begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end else begin
                    gv_re      = 1'b1;
                    gv_raddr   = VIDX_W'(req_reg.slot);
                    state_next = S_RD_VID;
                end
            end
            S_RD_VID: begin
                add_a              = W'(gv_rdata);
                add_b              = W'(cfg.id_offset);
                res_next.vertex_id = add_res[15:0];
                state_next         = S_DONE;
            end
            // Group info read.
            S_RD_GRP: begin
                if (group_beyond) begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end else begin
                    gf_re      = 1'b1;
                    gf_raddr   = PIDX_W'(req_reg.group);
                    gc_re      = 1'b1;
                    gc_raddr   = PIDX_W'(req_reg.group);
                    state_next = S_RD_GINFO;
                end
            end
            S_RD_GINFO: begin
                res_next.group_start  = 11'(gf_rdata);
                res_next.group_length = 11'(gc_rdata);
                state_next            = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    clr_reply_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            loaded_reg    <= '0;
            built_reg     <= 1'b0;
            clr_reply_reg <= 1'b0;
            g_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            built_reg     <= built_next;
            clr_reply_reg <= clr_reply_next;
            g_reg         <= g_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        v_reg      <= v_next;
        run_reg    <= run_next;
        diff_reg   <= diff_next;
        borrow_reg <= borrow_next;
    end

    // Vertex position store.
    always_ff @(posedge aclk) begin
        if (vp_we) begin
            vp_mem[vp_waddr] <= vp_wdata;
        end
        if (vp_re) begin
            vp_rdata <= vp_mem[vp_raddr];
        end
    end

    // Per-group vertex counts.
    always_ff @(posedge aclk) begin
        if (gc_we) begin
            gc_mem[gc_waddr] <= gc_wdata;
        end
        if (gc_re) begin
            gc_rdata <= gc_mem[gc_raddr];
        end
    end

    // Group first slots.
    always_ff @(posedge aclk) begin
        if (gf_we) begin
            gf_mem[gf_waddr] <= gf_wdata;
        end
        if (gf_re) begin
            gf_rdata <= gf_mem[gf_raddr];
        end
    end

    // Scatter fill cursors.
    always_ff @(posedge aclk) begin
        if (fc_we) begin
            fc_mem[fc_waddr] <= fc_wdata;
        end
        if (fc_re) begin
            fc_rdata <= fc_mem[fc_raddr];
        end
    end

    // Grouped vertex list.
    always_ff @(posedge aclk) begin
        if (gv_we) begin
            gv_mem[gv_waddr] <= gv_wdata;
        end
        if (gv_re) begin
            gv_rdata <= gv_mem[gv_raddr];
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // A read is only served from a built index.
    a_read_needs_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD_SLOT || state_reg == S_RD_GRP) |-> built_reg)
        else $error("read served without a built index");

    // The index becomes valid only at the end of a build pass.
    a_built_from_build: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(built_reg) |-> ($past(state_reg) == S_B_SC_WR || $past(state_reg) == S_B_SUM_WR))
        else $error("index marked built outside a build pass");

    // A waiting result holds until it is handed over.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && $past(state_reg) == S_DONE) |-> $stable(res_reg))
        else $error("pending result changed");

    // The loaded count only steps up by one or returns to zero.
    a_loaded_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (loaded_reg != $past(loaded_reg)) |->
            (loaded_reg == $past(loaded_reg) + CNT_W'(1) || loaded_reg == '0))
        else $error("loaded count jumped");

endmodule

// ----- src/vertex_group_index_builder.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_operation, s_raw_position, s_slot, s_group
// m_        out        m_valid / m_ready    m_vertex_id, m_group_start, m_group_length, m_status
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A stored load steps through S_LD_SUB, S_LD_CHK and S_LD_INC to S_DONE, a rejected one
// skips S_LD_INC, and a slot or group read steps through its read and data states, or
// goes straight to S_DONE when out of range. The first read after a load or clear first
// runs the build: a read and a write state per position over MAX_POSITIONS positions,
// then a position read, a cursor read and a write per loaded vertex, all on one memory port
// each. A clear, and reset before s_ready rises, zero the count memory one entry a cycle.
// A new request is taken while a result waits in the output register; a stalled
// m_ready holds the next result inside the block and keeps s_ready low.
module vertex_group_index_builder
    import vgib_pkg::*;
#(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_POSITIONS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_raw_position,
    input  logic [9:0]  s_slot,
    input  logic [7:0]  s_group,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_vertex_id,
    output logic [10:0] m_group_start,
    output logic [10:0] m_group_length,
    output logic [1:0]  m_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    vgib_cfg_t cfg_reg, cfg_next;
    vgib_req_t req;
    vgib_res_t core_res;
    vgib_res_t out_reg, out_next;
    logic      m_valid_reg, m_valid_next;
    logic      core_idle;
    logic      core_valid;
    logic      res_ready;

    assign req.operation    = s_operation;
    assign req.raw_position = s_raw_position;
    assign req.slot         = s_slot;
    assign req.group        = s_group;

    // Configuration writes; an unknown index is ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_NUM_POSITIONS: cfg_next.num_positions = cfg_data[8:0];
                CFG_POSITION_BASE: cfg_next.position_base = cfg_data;
                CFG_ID_OFFSET:     cfg_next.id_offset     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Output register is free when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (core_valid && res_ready) begin
            out_next     = core_res;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_positions <= 9'd256;
            cfg_reg.position_base <= 16'd1;
            cfg_reg.id_offset     <= 16'd0;
            m_valid_reg           <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    vgib_core #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && s_ready),
        .req       (req),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res_ready (res_ready),
        .res       (core_res)
    );

    assign s_ready        = core_idle;
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_vertex_id    = out_reg.vertex_id;
    assign m_group_start  = out_reg.group_start;
    assign m_group_length = out_reg.group_length;
    assign m_status       = out_reg.status;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import vgib_pkg::*;

    localparam int MAX_VERTS   = 1024;
    localparam int NUM_GROUPS  = 256;
    localparam int STALL_LIMIT = 20000;
    localparam int IDLE_PCT    = 12;
    // Budget of the random phases; the fill phase at the end adds about MAX_VERTS more.
    localparam int RANDOM_ITEMS = 80;

    // Index past the register list; writes to it must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation    = OP_LOAD;
    logic [15:0] s_raw_position = '0;
    logic [9:0]  s_slot         = '0;
    logic [7:0]  s_group        = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [15:0] m_vertex_id;
    logic [10:0] m_group_start;
    logic [10:0] m_group_length;
    logic [1:0]  m_status;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index      = CFG_NUM_POSITIONS;
    logic [15:0] cfg_data       = '0;

    vertex_group_index_builder #(
        .MAX_VERTICES (MAX_VERTS),
        .MAX_POSITIONS(NUM_GROUPS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_raw_position(s_raw_position),
        .s_slot        (s_slot),
        .s_group       (s_group),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex_id   (m_vertex_id),
        .m_group_start (m_group_start),
        .m_group_length(m_group_length),
        .m_status      (m_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shadow of the block: configuration, stored vertices and the grouped index.
    logic [8:0]  cfg_groups = 9'd256;
    logic [15:0] cfg_base   = 16'd1;
    logic [15:0] cfg_offset = 16'd0;
    logic [7:0]  vertex_group [MAX_VERTS];
    logic [10:0] group_size   [NUM_GROUPS] = '{default: '0};
    logic [10:0] group_base   [NUM_GROUPS];
    logic [10:0] group_fill   [NUM_GROUPS];
    logic [9:0]  slot_vertex  [MAX_VERTS];
    logic [10:0] stored_total = '0;
    logic        index_ready  = 1'b0;

    vgib_req_t queued_requests[$];
    vgib_res_t awaited_replies[$];
    vgib_req_t shown_req;
    int        issued_count   = 0;
    int        accepted_count = 0;
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    logic      steady         = 1'b0;

    function automatic logic [8:0] active_groups();
        return (cfg_groups > NUM_GROUPS) ? 9'(NUM_GROUPS) : cfg_groups;
    endfunction

    // Counting sort: prefix sum of the group sizes, then a stable scatter of vertices.
    function automatic void sort_into_groups();
        logic [10:0] run;
        logic [10:0] at;
        logic [7:0]  g;
        run = '0;
        for (int i = 0; i < NUM_GROUPS; i++) begin
            group_base[i] = run;
            group_fill[i] = run;
            run = run + group_size[i];
        end
        for (int v = 0; v < stored_total; v++) begin
            g  = vertex_group[v];
            at = group_fill[g];
            if (at < MAX_VERTS) begin
                slot_vertex[at[9:0]] = 10'(v);
            end
            group_fill[g] = at + 11'd1;
        end
        index_ready = 1'b1;
    endfunction

    // Applies one request to the shadow and returns the reply it must produce.
    function automatic vgib_res_t index_reply(vgib_req_t r);
        vgib_res_t   res;
        logic [15:0] pos;
        res = '0;
        case (r.operation)
            OP_LOAD: begin
                if (r.raw_position < cfg_base || r.raw_position - cfg_base >= active_groups()) begin
                    res.status = ST_RANGE;
                end else if (stored_total >= MAX_VERTS) begin
                    res.status = ST_FULL;
                end else begin
                    pos = r.raw_position - cfg_base;
                    vertex_group[stored_total[9:0]] = pos[7:0];
                    group_size[pos[7:0]] = group_size[pos[7:0]] + 11'd1;
                    stored_total = stored_total + 11'd1;
                    index_ready = 1'b0;
                end
            end
            OP_SLOT: begin
                if (!index_ready) begin
                    sort_into_groups();
                end
                if (r.slot >= stored_total) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.vertex_id = 16'(slot_vertex[r.slot]) + cfg_offset;
                end
            end
            OP_GROUP: begin
                if (!index_ready) begin
                    sort_into_groups();
                end
                if (r.group >= active_groups()) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.group_start  = group_base[r.group];
                    res.group_length = group_size[r.group];
                end
            end
            default: begin
                group_size   = '{default: '0};
                stored_total = '0;
                index_ready  = 1'b0;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // Request driver: presents queued requests and records each accepted one.
    always @(posedge aclk) begin : request_driver
        vgib_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_replies.push_back(index_reply(shown_req));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (queued_requests.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = queued_requests.pop_front();
                    shown_req = nxt;
                    s_valid        <= 1'b1;
                    s_operation    <= nxt.operation;
                    s_raw_position <= nxt.raw_position;
                    s_slot         <= nxt.slot;
                    s_group        <= nxt.group;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: compares each accepted reply with the oldest one awaited.
    always @(posedge aclk) begin : reply_monitor
        vgib_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch("reply with no request outstanding");
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("vertex_id", m_vertex_id, want.vertex_id);
                    compare_field("group_start", 16'(m_group_start), 16'(want.group_start));
                    compare_field("group_length", 16'(m_group_length),
                                  16'(want.group_length));
                    compare_field("status", 16'(m_status), 16'(want.status));
                end
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: ends the run when no handshake of any channel happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_request(logic [1:0] op, logic [15:0] raw, logic [9:0] slot,
                                logic [7:0] grp);
        vgib_req_t r;
        r.operation    = op;
        r.raw_position = raw;
        r.slot         = slot;
        r.group        = grp;
        queued_requests.push_back(r);
        issued_count++;
    endtask

    // Load request, mostly inside the group range and biased toward a few hot groups.
    task automatic push_load(int groups_n, inout int planned);
        int          pick;
        logic [15:0] raw;
        pick = $urandom_range(99);
        if (groups_n > 0 && pick < 40) begin
            raw = cfg_base + 16'($urandom_range(groups_n - 1));
        end else if (groups_n > 0 && pick < 80) begin
            raw = cfg_base + 16'($urandom_range(groups_n < 4 ? groups_n - 1 : 3));
        end else if (pick < 87 && cfg_base > 0) begin
            raw = 16'($urandom_range(cfg_base - 1));
        end else if (pick < 94) begin
            raw = cfg_base + 16'(groups_n) + 16'($urandom_range(3));
        end else begin
            raw = 16'($urandom);
        end
        if (raw >= cfg_base && raw - cfg_base < groups_n && planned < MAX_VERTS) begin
            planned++;
        end
        push_request(OP_LOAD, raw, 10'($urandom), 8'($urandom));
    endtask

    // Slot or group read, mostly within what is loaded, sometimes just past it.
    task automatic push_read(int groups_n, int planned);
        int         pick;
        logic [9:0] slot;
        logic [7:0] grp;
        pick = $urandom_range(99);
        if (planned > 0 && pick < 75) begin
            slot = 10'($urandom_range(planned - 1));
        end else if (pick < 90) begin
            slot = 10'(planned + $urandom_range(2));
        end else begin
            slot = 10'($urandom);
        end
        pick = $urandom_range(99);
        if (groups_n > 0 && pick < 75) begin
            grp = 8'($urandom_range(groups_n - 1));
        end else if (pick < 90) begin
            grp = 8'(groups_n + $urandom_range(2));
        end else begin
            grp = 8'($urandom);
        end
        push_request($urandom_range(1) ? OP_SLOT : OP_GROUP, 16'($urandom), slot, grp);
    endtask

    // Returns once every issued request has been accepted and answered.
    task automatic wait_drained();
        do @(posedge aclk);
        while (accepted_count != issued_count || awaited_replies.size() != 0);
    endtask

    // Call at a clock edge; leaves cfg_valid high for the caller to lower.
    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_NUM_POSITIONS: cfg_groups = value[8:0];
            CFG_POSITION_BASE: cfg_base = value;
            CFG_ID_OFFSET:     cfg_offset = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [8:0] groups_n, logic [15:0] base, logic [15:0] offset);
        write_register(CFG_NUM_POSITIONS, {7'd0, groups_n});
        write_register(CFG_POSITION_BASE, base);
        write_register(CFG_ID_OFFSET, offset);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          start_count;
        int          planned;
        int          groups_n;
        int          n;
        logic [8:0]  new_groups;
        logic [15:0] new_base;
        logic [15:0] new_offset;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty reads, range edges of loads, grouped order, clear.
        push_request(OP_SLOT, 16'd0, 10'd0, 8'd0);
        push_request(OP_GROUP, 16'd0, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'd0, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'd1, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'd256, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'd257, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'hFFFF, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'd256, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'd1, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'd128, 10'd0, 8'd0);
        for (int i = 0; i < 5; i++) begin
            push_request(OP_SLOT, 16'd0, 10'(i), 8'd0);
        end
        push_request(OP_SLOT, 16'd0, 10'h3FF, 8'd0);
        push_request(OP_GROUP, 16'd0, 10'd0, 8'd255);
        push_request(OP_GROUP, 16'd0, 10'd0, 8'd127);
        push_request(OP_CLEAR, 16'd0, 10'd0, 8'd0);
        push_request(OP_SLOT, 16'd0, 10'd0, 8'd0);
        wait_drained();

        // Zero groups in use: every load and every group read fails.
        write_register(CFG_SPARE, 16'hFFFF);
        configure(9'd0, 16'd0, 16'd64512);
        push_request(OP_LOAD, 16'd0, 10'd0, 8'd0);
        push_request(OP_GROUP, 16'd0, 10'd0, 8'd0);
        wait_drained();

        // Group count above the maximum saturates; highest base.
        configure(9'd511, 16'hFFFF, 16'd64512);
        push_request(OP_LOAD, 16'hFFFF, 10'd0, 8'd0);
        push_request(OP_LOAD, 16'hFFFE, 10'd0, 8'd0);
        push_request(OP_SLOT, 16'd0, 10'd0, 8'd0);
        push_request(OP_GROUP, 16'd0, 10'd0, 8'd255);
        push_request(OP_GROUP, 16'd0, 10'd0, 8'd0);
        wait_drained();

        // Random phases: optional new settings, optional clear, loads, then reads.
        start_count = issued_count;
        while (issued_count - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(4))
                    0: new_groups = 9'd1;
                    1: new_groups = 9'd256;
                    2: new_groups = 9'd2;
                    default: new_groups = 9'($urandom_range(1, 256));
                endcase
                case ($urandom_range(4))
                    0: new_base = 16'd0;
                    1: new_base = 16'hFFFF - 16'(new_groups) + 16'd1;
                    2: new_base = 16'hFFFF;
                    default: new_base = 16'($urandom_range(0, 60000));
                endcase
                case ($urandom_range(3))
                    0: new_offset = 16'd0;
                    1: new_offset = 16'd64512;
                    default: new_offset = 16'($urandom_range(0, 64512));
                endcase
                configure(new_groups, new_base, new_offset);
            end
            planned  = stored_total;
            groups_n = active_groups();
            if ($urandom_range(9) < 6) begin
                push_request(OP_CLEAR, 16'($urandom), 10'($urandom), 8'($urandom));
                planned = 0;
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            repeat (n) push_load(groups_n, planned);
            n = $urandom_range(5, 40);
            repeat (n) begin
                // A stray load or clear among the reads forces a fresh build.
                case ($urandom_range(49))
                    0, 1: push_load(groups_n, planned);
                    2: begin
                        push_request(OP_CLEAR, 16'($urandom), 10'($urandom), 8'($urandom));
                        planned = 0;
                    end
                    default: push_read(groups_n, planned);
                endcase
            end
            wait_drained();
        end

        // Fill the store to the top without idling, then overflow it.
        configure(9'($urandom_range(1, 256)), 16'($urandom_range(0, 65535 - 256)),
                  16'd64512);
        steady   = 1'b1;
        groups_n = active_groups();
        push_request(OP_CLEAR, 16'd0, 10'd0, 8'd0);
        repeat (MAX_VERTS + 4) begin
            push_request(OP_LOAD, cfg_base + 16'($urandom_range(groups_n - 1)),
                         10'($urandom), 8'($urandom));
        end
        push_request(OP_LOAD, cfg_base + 16'(groups_n), 10'd0, 8'd0);
        push_request(OP_SLOT, 16'd0, 10'h3FF, 8'd0);
        push_request(OP_SLOT, 16'd0, 10'd0, 8'd0);
        repeat (40) push_read(groups_n, MAX_VERTS);
        wait_drained();
        steady = 1'b0;

        repeat (300) @(posedge aclk);
        if (awaited_replies.size() != 0) begin
            report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/vgib_pkg.sv
src/vgib_addsub.sv
src/vgib_core.sv
src/vertex_group_index_builder.sv
sim/tb_top.sv
